// ===== design/thick_midpoint_line_rasterizer_macros.svh =====
// Assertion macros for the thick midpoint line rasterizer checker.
// Expects signals named clk and rst_n in the scope where they are used.
`ifndef THICK_MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define THICK_MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TMLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TMLR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tmlr_pkg.sv =====
// Shared types and constants for the thick midpoint line rasterizer.
// No dependencies; used by the controller, datapath and top level.
package tmlr_pkg;

    // Default parameter values
    localparam int DEF_COORD_BITS        = 10;
    localparam int DEF_MAX_HALF_THICKNESS = 7;

    // Fixed field widths
    localparam int HT_W    = 3;   // half_thickness register
    localparam int PIX_Y_W = 12;  // pixel_y output, two's complement

    // Input beat kind, carried on tuser
    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // latch endpoints from the input beat
        logic emit;   // push the current pixel into the output register
    } tmlr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic line_active;  // a line is loaded and has columns left
        logic pixel_last;   // current pixel closes the column run
        logic out_free;     // output register can take a beat this cycle
    } tmlr_sts_t;

endpackage

// ===== design/thick_midpoint_line_rasterizer.sv =====
// Thick midpoint line rasterizer: a start beat (tuser 0) loads two endpoints and
// gives no output; each advance beat (tuser 1) emits the current column as a run
// of 1 + 2*h pixels (centre, then y-1, y+1, y-2, y+2, ...), h being half_thickness
// clamped to MAX_HALF_THICKNESS, and steps the line one column in x. On a loaded line an
// advance beat is accepted, then its pixels leave one per cycle through the single output
// register while the output does not stall; a stall holds the run until the beat is taken.
// The input stays ready after a start beat.
// The next beat is accepted while the last pixel of a run still waits on the output.
// m_axis_tlast marks the last pixel of a column, m_axis_tuser the last pixel of the
// line. No clearing pass after reset. Depends on tmlr_pkg, tmlr_ctrl, tmlr_datapath.
module thick_midpoint_line_rasterizer
    import tmlr_pkg::*;
#(
    parameter int COORD_BITS         = DEF_COORD_BITS,
    parameter int MAX_HALF_THICKNESS = DEF_MAX_HALF_THICKNESS,
    localparam int IN_W              = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W             = ((COORD_BITS + PIX_Y_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,   // x_start, y_start, x_end, y_end, zero pad
    input  logic                s_axis_tuser,   // operation
    // Output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // pixel_x, pixel_y, zero pad
    output logic                m_axis_tlast,   // column_last
    output logic                m_axis_tuser,   // line_done
    // Configuration
    input  logic                cfg_we,
    input  logic [HT_W-1:0]     cfg_wdata       // half_thickness
);

    tmlr_cmd_t cmd;
    tmlr_sts_t sts;

    // Sequencer
    tmlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_user  (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Line state and pixel generation
    tmlr_datapath #(
        .COORD_BITS         (COORD_BITS),
        .MAX_HALF_THICKNESS (MAX_HALF_THICKNESS),
        .IN_W               (IN_W),
        .OUT_W              (OUT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

// ===== design/tmlr_ctrl.sv =====
// Controller for the thick midpoint line rasterizer: input handshake and run sequencing.
// Depends on tmlr_pkg.
module tmlr_ctrl
    import tmlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      in_user,
    input  tmlr_sts_t sts,
    output tmlr_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    op_t    op;

    // Input beats are taken only between column runs
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign op       = op_t'(in_user);

    assign cmd.load = in_fire && (op == OP_START);
    assign cmd.emit = (state_reg == ST_RUN) && sts.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op == OP_ADVANCE) && sts.line_active)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && sts.pixel_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tmlr_datapath.sv =====
// Datapath for the thick midpoint line rasterizer: line setup, decision term,
// run index and output register. Depends on tmlr_pkg.
module tmlr_datapath
    import tmlr_pkg::*;
#(
    parameter int COORD_BITS         = DEF_COORD_BITS,
    parameter int MAX_HALF_THICKNESS = DEF_MAX_HALF_THICKNESS,
    parameter int IN_W               = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W              = ((COORD_BITS + PIX_Y_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tmlr_cmd_t        cmd,
    output tmlr_sts_t        sts,
    input  logic [IN_W-1:0]  in_data,
    input  logic             cfg_we,
    input  logic [HT_W-1:0]  cfg_wdata,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data,
    output logic             out_last,
    output logic             out_user
);

    localparam int DEC_W = COORD_BITS + 4;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int YE_W  = (COORD_BITS + 1 > PIX_Y_W) ? COORD_BITS + 1 : PIX_Y_W;
    localparam logic signed [DEC_W-1:0] DEC_MAX = {1'b0, {(DEC_W-1){1'b1}}};
    localparam logic signed [DEC_W-1:0] DEC_MIN = {1'b1, {(DEC_W-1){1'b0}}};

    // Configuration and line state
    logic [HT_W-1:0]         half_thickness_reg;
    logic                    line_active_reg;
    logic                    line_active_next;
    logic [COORD_BITS-1:0]   cur_x_reg;
    logic [COORD_BITS-1:0]   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg;
    logic [COORD_BITS-1:0]   cur_y_next;
    logic [COORD_BITS-1:0]   end_x_reg;
    logic                    going_up_reg;
    logic signed [DEC_W-1:0] decision_reg;
    logic signed [DEC_W-1:0] decision_next;
    logic signed [DEC_W-1:0] step_straight_reg;
    logic signed [DEC_W-1:0] step_diagonal_reg;

    // Run index: distance from centre and which side
    logic [HT_W-1:0]         idx_reg;
    logic [HT_W-1:0]         idx_next;
    logic                    plus_reg;
    logic                    plus_next;

    // Output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_last_reg;
    logic                    out_user_reg;

    // Setup terms
    logic [COORD_BITS-1:0]   xs;
    logic [COORD_BITS-1:0]   ys;
    logic [COORD_BITS-1:0]   xe;
    logic [COORD_BITS-1:0]   ye;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] dy;
    logic signed [DEC_W-1:0] dx_e;
    logic signed [DEC_W-1:0] dy_e;
    logic                    up_in;

    // Column terms
    logic [HT_W-1:0]         h;
    logic                    pixel_last;
    logic                    final_col;
    logic [YE_W-1:0]         y_sum;
    logic                    take_diag;
    logic signed [DEC_W-1:0] dec_step;
    logic signed [DEC_W:0]   dec_sum;

    // Unpack endpoints
    assign xs = in_data[COORD_BITS-1:0];
    assign ys = in_data[2*COORD_BITS-1:COORD_BITS];
    assign xe = in_data[3*COORD_BITS-1:2*COORD_BITS];
    assign ye = in_data[4*COORD_BITS-1:3*COORD_BITS];

    assign dx    = $signed({1'b0, xe}) - $signed({1'b0, xs});
    assign dy    = $signed({1'b0, ye}) - $signed({1'b0, ys});
    assign dx_e  = DEC_W'(dx);
    assign dy_e  = DEC_W'(dy);
    assign up_in = (ye > ys);

    // Effective half thickness
    always_comb
    begin
        if (32'(half_thickness_reg) > MAX_HALF_THICKNESS)
        begin
            h = HT_W'(MAX_HALF_THICKNESS);
        end
        else
        begin
            h = half_thickness_reg;
        end
    end

    assign pixel_last = (idx_reg == h) && (plus_reg || (h == '0));
    assign final_col  = (cur_x_reg == end_x_reg);

    // Pixel row: centre, then below / above by idx
    always_comb
    begin
        if (plus_reg)
        begin
            y_sum = YE_W'(cur_y_reg) + YE_W'(idx_reg);
        end
        else
        begin
            y_sum = YE_W'(cur_y_reg) - YE_W'(idx_reg);
        end
    end

    // Decision update with saturation
    assign take_diag = going_up_reg ? (decision_reg > 0) : (decision_reg < 0);
    assign dec_step  = take_diag ? step_diagonal_reg : step_straight_reg;
    assign dec_sum   = {decision_reg[DEC_W-1], decision_reg} + {dec_step[DEC_W-1], dec_step};

    always_comb
    begin
        priority if (dec_sum[DEC_W] == dec_sum[DEC_W-1])
        begin
            decision_next = dec_sum[DEC_W-1:0];
        end
        else if (dec_sum[DEC_W])
        begin
            decision_next = DEC_MIN;
        end
        else
        begin
            decision_next = DEC_MAX;
        end
    end

    // Column advance
    always_comb
    begin
        cur_y_next = cur_y_reg;
        if (take_diag)
        begin
            cur_y_next = going_up_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
        end
        cur_x_next       = final_col ? cur_x_reg : cur_x_reg + 1'b1;
        line_active_next = !final_col;
    end

    // Run index sequence: 0, 1-, 1+, 2-, 2+, ...
    always_comb
    begin
        idx_next  = idx_reg;
        plus_next = plus_reg;
        priority if (pixel_last)
        begin
            idx_next  = '0;
            plus_next = 1'b0;
        end
        else if (idx_reg == '0)
        begin
            idx_next  = HT_W'(1);
            plus_next = 1'b0;
        end
        else if (!plus_reg)
        begin
            plus_next = 1'b1;
        end
        else
        begin
            idx_next  = idx_reg + 1'b1;
            plus_next = 1'b0;
        end
    end

    // Output valid: set on emit, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_thickness_reg <= '0;
            line_active_reg    <= 1'b0;
            idx_reg            <= '0;
            plus_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_thickness_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                line_active_reg <= (xe >= xs);
            end
            else if (cmd.emit && pixel_last)
            begin
                line_active_reg <= line_active_next;
            end
            if (cmd.emit)
            begin
                idx_reg  <= idx_next;
                plus_reg <= plus_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Line payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg         <= xs;
            cur_y_reg         <= ys;
            end_x_reg         <= xe;
            going_up_reg      <= up_in;
            step_straight_reg <= dy_e + dy_e;
            if (up_in)
            begin
                decision_reg      <= dy_e + dy_e - dx_e;
                step_diagonal_reg <= (dy_e - dx_e) + (dy_e - dx_e);
            end
            else
            begin
                decision_reg      <= dy_e + dy_e + dx_e;
                step_diagonal_reg <= (dy_e + dx_e) + (dy_e + dx_e);
            end
        end
        else if (cmd.emit && pixel_last)
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            decision_reg <= decision_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= OUT_W'({y_sum[PIX_Y_W-1:0], cur_x_reg});
            out_last_reg <= pixel_last;
            out_user_reg <= pixel_last && final_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

    assign sts.line_active = line_active_reg;
    assign sts.pixel_last  = pixel_last;
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== design/tmlr_checker.sv =====
// Port-level checker for the thick midpoint line rasterizer, bound to the top level.
// Depends on tmlr_pkg and thick_midpoint_line_rasterizer_macros.svh.
`include "thick_midpoint_line_rasterizer_macros.svh"

module tmlr_checker
    import tmlr_pkg::*;
#(
    parameter int IN_W  = 40,
    parameter int OUT_W = 24
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    logic start_beat;

    assign start_beat = s_axis_tvalid && s_axis_tready && (op_t'(s_axis_tuser) == OP_START);

    // A stalled output beat holds
    `TMLR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output beat changed while stalled")

    // End of line is always the end of a column
    `TMLR_ASSERT_IMP(a_done_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "line_done without column_last")

    // A start beat launches no run: input stays open
    `TMLR_ASSERT_NXT(a_start_open, start_beat, s_axis_tready, "input closed after start beat")

    // Pixels only appear out of a run, when input was closed
    `TMLR_ASSERT_IMP(a_out_from_run, $rose(m_axis_tvalid), !$past(s_axis_tready), "output beat without a run")

endmodule

bind thick_midpoint_line_rasterizer tmlr_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_tmlr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_thick_midpoint_line_rasterizer.sv =====
// Self-checking bench for thick_midpoint_line_rasterizer: drives start/advance
// beats, predicts every emitted pixel and compares it on the output stream.
// Depends on tmlr_pkg and the rasterizer RTL only.
`timescale 1ns / 100ps

module tb_thick_midpoint_line_rasterizer;
    import tmlr_pkg::*;

    localparam int CRD_W        = 10;
    localparam int BEAT_W       = 40;      // four 10-bit coordinates
    localparam int PIX_W        = 24;      // pixel_x, pixel_y, two pad bits
    localparam int DEC_MAX      = 8191;    // decision term is 14-bit signed
    localparam int DEC_MIN      = -8192;
    localparam int SETTLE       = 24;      // quiet cycles before a register write
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [CRD_W-1:0]   x;
        logic [PIX_Y_W-1:0] y;
        logic               col_last;
        logic               line_end;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BEAT_W-1:0]  s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [PIX_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;
    logic               cfg_we = 1'b0;
    logic [HT_W-1:0]    cfg_wdata = '0;

    // Rasterizer state as predicted by the bench
    logic [CRD_W-1:0]   ln_x;
    logic [CRD_W-1:0]   ln_y;
    logic [CRD_W-1:0]   ln_end;
    int                 dec_term;
    int                 inc_straight;
    int                 inc_diag;
    bit                 ln_up;
    bit                 ln_live;
    int                 half_thick;

    pixel_t             pixel_q[$];
    int                 useful_beats = 0;
    int                 mismatches = 0;
    int                 cycle_cnt = 0;
    bit                 calm = 1'b0;       // no random idling on either side
    int                 hold_trig = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;

    thick_midpoint_line_rasterizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output ready: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_trig != hold_seen)
        begin
            hold_seen     <= hold_trig;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    // Pixel checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("pixel beat with none expected: x=%0d y=%0d",
                       m_axis_tdata[9:0], $signed(m_axis_tdata[21:10]));
                mismatches++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[9:0] !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, m_axis_tdata[9:0]);
                    mismatches++;
                end
                if (m_axis_tdata[21:10] !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d",
                           $signed(want.y), $signed(m_axis_tdata[21:10]));
                    mismatches++;
                end
                if (m_axis_tlast !== want.col_last)
                begin
                    $error("column_last: expected %0b, got %0b", want.col_last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.line_end)
                begin
                    $error("line_done: expected %0b, got %0b", want.line_end, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    function automatic int clamp_dec(int v);
        if (v > DEC_MAX)
            return DEC_MAX;
        if (v < DEC_MIN)
            return DEC_MIN;
        return v;
    endfunction

    function automatic void push_pixel(int y, bit col_last, bit line_end);
        pixel_t p;
        p.x        = ln_x;
        p.y        = PIX_Y_W'(y);
        p.col_last = col_last;
        p.line_end = line_end;
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    // Predict the pixels of one accepted beat and step the line state
    function automatic void rasterize_beat(op_t op, logic [CRD_W-1:0] xs, logic [CRD_W-1:0] ys,
                                           logic [CRD_W-1:0] xe, logic [CRD_W-1:0] ye);
        int  dx;
        int  dy;
        int  yc;
        bit  final_col;
        if (op == OP_START)
        begin
            dx           = int'(xe) - int'(xs);
            dy           = int'(ye) - int'(ys);
            ln_x         = xs;
            ln_y         = ys;
            ln_end       = xe;
            ln_up        = ye > ys;
            inc_straight = 2 * dy;
            if (ln_up)
            begin
                dec_term = clamp_dec(2 * dy - dx);
                inc_diag = 2 * (dy - dx);
            end
            else
            begin
                dec_term = clamp_dec(2 * dy + dx);
                inc_diag = 2 * (dy + dx);
            end
            ln_live = xe >= xs;
            useful_beats++;
            return;
        end
        if (!ln_live)
            return;
        useful_beats++;

        // Column run: centre, then below/above pairs
        final_col = ln_x == ln_end;
        yc        = int'(ln_y);
        push_pixel(yc, half_thick == 0, final_col && half_thick == 0);
        for (int i = 1; i <= half_thick; i++)
        begin
            push_pixel(yc - i, 1'b0, 1'b0);
            push_pixel(yc + i, i == half_thick, final_col && i == half_thick);
        end

        // Midpoint step
        if (ln_up)
        begin
            if (dec_term > 0)
            begin
                dec_term = clamp_dec(dec_term + inc_diag);
                ln_y     = ln_y + 1'b1;
            end
            else
                dec_term = clamp_dec(dec_term + inc_straight);
        end
        else
        begin
            if (dec_term < 0)
            begin
                dec_term = clamp_dec(dec_term + inc_diag);
                ln_y     = ln_y - 1'b1;
            end
            else
                dec_term = clamp_dec(dec_term + inc_straight);
        end

        if (final_col)
            ln_live = 1'b0;
        else
            ln_x = ln_x + 1'b1;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 1023));
    endfunction

    // Offer one beat, hold it until accepted; called and returns at a rising edge
    task automatic send_beat(op_t op, int xs, int ys, int xe, int ye);
        int gap;
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {CRD_W'(ye), CRD_W'(xe), CRD_W'(ys), CRD_W'(xs)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        rasterize_beat(op, CRD_W'(xs), CRD_W'(ys), CRD_W'(xe), CRD_W'(ye));
    endtask

    task automatic send_advance();
        send_beat(OP_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    // Stop offering and wait for every predicted pixel, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_thickness(int v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= HT_W'(v);
        @(posedge clk);
        cfg_we     <= 1'b0;
        half_thick = v;
    endtask

    // Random traffic: mostly complete lines, some cut short or overrun, some noise
    task automatic run_random(int n_beats);
        int stop;
        int kind;
        int len;
        int adv;
        int xs;
        int ys;
        int xe;
        int ye;
        stop = useful_beats + n_beats;
        while (useful_beats < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 8);
                xs  = $urandom_range(0, 1023 - len);
                xe  = xs + len;
                case ($urandom_range(0, 3))
                    0: ys = $urandom_range(0, 7);
                    1: ys = $urandom_range(1016, 1023);
                    default: ys = $urandom_range(0, 1023);
                endcase
                case ($urandom_range(0, 3))
                    0: ye = $urandom_range(0, 1023);
                    1: ye = ys;
                    2: ye = ys + int'($urandom_range(0, len + 3));
                    default: ye = ys - int'($urandom_range(0, len + 3));
                endcase
                if (ye < 0)
                    ye = 0;
                if (ye > 1023)
                    ye = 1023;
                adv = len + 1;
                if ($urandom_range(0, 4) == 0)
                    adv = $urandom_range(1, len + 1);
                if ($urandom_range(0, 4) == 0)
                    adv++;
                send_beat(OP_START, xs, ys, xe, ye);
                repeat (adv) send_advance();
            end
            else if (kind < 90)
            begin
                // Reversed endpoints: line has no pixels
                xs = $urandom_range(1, 1023);
                xe = $urandom_range(0, xs - 1);
                send_beat(OP_START, xs, any_coord(), xe, any_coord());
                if ($urandom_range(0, 1) == 1)
                    send_advance();
            end
            else
                send_advance();
        end
    endtask

    // Extremes of the fields and each special case of the line setup
    task automatic test_directed();
        send_advance();                                   // idle, no line loaded
        send_beat(OP_START, 0, 0, 3, 2);                  // shallow upward
        repeat (5) send_advance();                        // last one runs past the end
        write_thickness(7);
        send_beat(OP_START, 1020, 1023, 1023, 1023);      // horizontal at the top row
        repeat (2) send_advance();
        send_beat(OP_START, 512, 0, 512, 1023);           // vertical: one column only
        repeat (2) send_advance();
        send_beat(OP_START, 1023, 5, 0, 9);               // reversed: nothing drawn
        send_advance();
        send_beat(OP_START, 5, 1000, 8, 3);               // steep downward, saturates
        repeat (4) send_advance();
        send_beat(OP_START, 100, 200, 110, 204);          // replaced mid-line
        send_advance();
        send_beat(OP_START, 1021, 1, 1023, 1023);         // steep upward at right edge
        repeat (2) send_advance();
    endtask

    task automatic test_random_thickness();
        write_thickness(3);
        run_random(10);
        write_thickness(0);
        run_random(10);
        write_thickness($urandom_range(1, 6));
        run_random(10);
    endtask

    task automatic test_back_to_back();
        write_thickness(7);
        calm = 1'b1;
        run_random(10);
        calm = 1'b0;
    endtask

    // Output held off while the input keeps offering beats
    task automatic test_output_hold();
        write_thickness(7);
        send_beat(OP_START, 300, 40, 319, 30);
        hold_trig++;
        repeat (12) send_advance();
        wait_drained();
    endtask

    // Input goes quiet until every pixel of the line is out, then continues it
    task automatic test_pause_until_drained();
        write_thickness(2);
        send_beat(OP_START, 700, 600, 709, 606);
        repeat (4) send_advance();
        wait_drained();
        repeat (6) send_advance();
    endtask

    initial
    begin
        half_thick = 0;
        ln_x = '0;
        ln_y = '0;
        ln_end = '0;
        dec_term = 0;
        inc_straight = 0;
        inc_diag = 0;
        ln_up = 1'b0;
        ln_live = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_thickness();
        test_back_to_back();
        test_output_hold();
        test_pause_until_drained();

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
